// ===== rtl/core/lz4d_pkg.sv =====
// Shared types and constants for the LZ4 block decompressor.
// No dependencies.
`default_nettype none
package lz4d_pkg;
	localparam int unsigned WIN_AW     = 16;   // history window of 65536 bytes
	localparam int unsigned PULL_LANES = 8;
	localparam int unsigned LANE_W     = $clog2(PULL_LANES);
	localparam int unsigned CNT_W      = $clog2(PULL_LANES + 1);

	typedef enum logic [1:0] {
		REQ_PUSH    = 2'd0,
		REQ_PULL    = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_BAD     = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REFUSED  = 2'd1,
		ST_BADOFF   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_TOKEN  = 3'd0,
		PH_LITEXT = 3'd1,
		PH_LIT    = 3'd2,
		PH_OFFLO  = 3'd3,
		PH_OFFHI  = 3'd4,
		PH_MATEXT = 3'd5,
		PH_MATCH  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] in_byte;
		logic       in_last;
	} req_beat_t;

	typedef struct packed {
		logic [8*PULL_LANES-1:0] out_data;
		logic [3:0]              out_count;
		logic                    more_pending;
		logic                    block_done;
		logic [1:0]              status;
	} rsp_beat_t;
endpackage
`default_nettype wire

// ===== rtl/core/lz4d_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on lz4d_pkg.
`default_nettype none
interface lz4d_req_if import lz4d_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] in_byte;
	logic       in_last;
	modport source (output valid, req_type, in_byte, in_last, input ready);
	modport sink (input valid, req_type, in_byte, in_last, output ready);
endinterface

interface lz4d_rsp_if import lz4d_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [8*PULL_LANES-1:0] out_data;
	logic [3:0]              out_count;
	logic                    more_pending;
	logic                    block_done;
	logic [1:0]              status;
	modport source (output valid, out_data, out_count, more_pending, block_done, status,
		input ready);
	modport sink (input valid, out_data, out_count, more_pending, block_done, status,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lz4_block_decompressor_unit.sv =====
// LZ4 block decompressor top level: parser, history RAM and match copier.
// Depends on lz4d_pkg and the interfaces in lz4d_if.sv.
`default_nettype none
// One request beat in, one response beat out. A push or restart beat is
// accepted and its response is registered into the output register, so
// pushes stream back to back as long as each response is taken in the cycle
// it is offered; a response left waiting holds the input off. A
// pull of n match bytes (n = min(bytes left, 8)) holds the input off until
// it retires: the 64 KiB history RAM has one registered read port and is read
// once per byte, pipelined, with bytes whose source lies inside the current
// pull forwarded from the lane registers so overlapping copies repeat their
// pattern. History is not cleared; offsets are checked against bytes written.
module lz4_block_decompressor_unit import lz4d_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lz4d_req_if.sink   req,
	lz4d_rsp_if.source rsp
);
	logic [7:0] hist [2**WIN_AW];

	phase_t            phase_q;
	logic [31:0]       lit_left_q, match_left_q;
	logic [WIN_AW-1:0] off_q, wp_q;
	logic [WIN_AW:0]   bw_q;
	logic [3:0]        tok_low_q;
	logic              finished_q, ended_q;

	logic              busy_q;
	logic [CNT_W-1:0]  iss_q, n_q;
	logic              vld_s1;
	logic [LANE_W-1:0] lane_s1;
	logic [7:0]        lanes_q [PULL_LANES];
	logic [7:0]        rdata_s1;

	logic      ov_q;
	rsp_beat_t od_q;

	logic acc;
	assign req.ready = !busy_q && (!ov_q || rsp.ready);
	assign acc = req.valid && req.ready;

	// next-state for push / restart / refused beats
	phase_t            ph_n;
	logic [31:0]       lit_n, ml_n;
	logic [WIN_AW-1:0] off_n;
	logic [3:0]        tl_n;
	logic              fin_n, end_n, lit_wr;
	logic [1:0]        st_n;
	logic [32:0]       sum_l, sum_m;
	logic              pull_go, clr;

	always_comb begin
		ph_n = phase_q; lit_n = lit_left_q; ml_n = match_left_q; off_n = off_q;
		tl_n = tok_low_q; fin_n = finished_q; end_n = ended_q; st_n = ST_OK;
		lit_wr = 1'b0; pull_go = 1'b0; clr = 1'b0;
		sum_l = {1'b0, lit_left_q} + {25'd0, req.in_byte};
		sum_m = {1'b0, match_left_q} + {25'd0, req.in_byte};
		unique case (req_code_t'(req.req_type))
			REQ_RESTART: begin
				clr = 1'b1; ph_n = PH_TOKEN; lit_n = '0; ml_n = '0; off_n = '0;
				tl_n = '0; fin_n = 1'b0; end_n = 1'b0;
			end
			REQ_PULL: begin
				if (finished_q || phase_q != PH_MATCH) st_n = ST_REFUSED;
				else pull_go = 1'b1;
			end
			REQ_PUSH: begin
				if (finished_q || phase_q == PH_MATCH) begin
					st_n = ST_REFUSED;
				end else begin
					unique case (phase_q)
						PH_TOKEN: begin
							tl_n = req.in_byte[3:0];
							lit_n = {28'd0, req.in_byte[7:4]};
							if (req.in_byte[7:4] == 4'd15) ph_n = PH_LITEXT;
							else if (req.in_byte[7:4] == 4'd0) ph_n = PH_OFFLO;
							else ph_n = PH_LIT;
						end
						PH_LITEXT: begin
							if (sum_l[32]) begin
								st_n = ST_OVERFLOW; fin_n = 1'b1;
							end else begin
								lit_n = sum_l[31:0];
								if (req.in_byte != 8'd255) ph_n = PH_LIT;
							end
						end
						PH_LIT: begin
							lit_wr = 1'b1;
							lit_n = lit_left_q - 32'd1;
							if (lit_left_q == 32'd1) ph_n = PH_OFFLO;
						end
						PH_OFFLO: begin
							off_n = {8'd0, req.in_byte};
							ph_n = PH_OFFHI;
						end
						PH_OFFHI: begin
							off_n = {req.in_byte, off_q[7:0]};
							if (off_n == '0) begin
								if (tok_low_q == 4'd1) ph_n = PH_TOKEN;
								else fin_n = 1'b1;
							end else if ({1'b0, off_n} > bw_q) begin
								st_n = ST_BADOFF; fin_n = 1'b1;
							end else if (tok_low_q == 4'd15) begin
								ml_n = 32'd19; ph_n = PH_MATEXT;
							end else begin
								ml_n = {28'd0, tok_low_q} + 32'd4; ph_n = PH_MATCH;
							end
						end
						PH_MATEXT: begin
							if (sum_m[32]) begin
								st_n = ST_OVERFLOW; fin_n = 1'b1;
							end else begin
								ml_n = sum_m[31:0];
								if (req.in_byte != 8'd255) ph_n = PH_MATCH;
							end
						end
						default: ;
					endcase
					if (!fin_n && req.in_last) begin
						if (ph_n == PH_MATCH) end_n = 1'b1;
						else fin_n = 1'b1;
					end
				end
			end
			default: st_n = ST_REFUSED;
		endcase
	end

	// match copier: issue one read per lane, resolve one byte per cycle
	logic              issue;
	logic [CNT_W-1:0]  iss_lane, n_new;
	logic [WIN_AW-1:0] rd_addr;
	logic [7:0]        mval;
	logic [LANE_W-1:0] src_lane;
	logic              fwd, last_lane;
	logic [8*PULL_LANES-1:0] pdata;
	logic [31:0]       ml_after;

	assign n_new = (match_left_q < PULL_LANES) ? match_left_q[CNT_W-1:0]
		: CNT_W'(PULL_LANES);
	assign issue    = (acc && pull_go) || (busy_q && iss_q < n_q);
	assign iss_lane = (acc && pull_go) ? '0 : iss_q;
	assign rd_addr  = wp_q - off_q + WIN_AW'(iss_lane);
	assign fwd      = {{(WIN_AW-LANE_W){1'b0}}, lane_s1} >= off_q;
	assign src_lane = lane_s1 - off_q[LANE_W-1:0];
	assign mval     = fwd ? lanes_q[src_lane] : rdata_s1;
	assign last_lane = vld_s1 && (CNT_W'(lane_s1) == n_q - CNT_W'(1));
	assign ml_after = match_left_q - {{(32-CNT_W){1'b0}}, n_q};

	always_comb begin
		for (int i = 0; i < PULL_LANES; i++) begin
			if (LANE_W'(i) == lane_s1) pdata[8*i +: 8] = mval;
			else if (CNT_W'(i) < n_q) pdata[8*i +: 8] = lanes_q[i];
			else pdata[8*i +: 8] = 8'd0;
		end
	end

	// history RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (vld_s1) hist[wp_q + WIN_AW'(lane_s1)] <= mval;
		else if (acc && lit_wr) hist[wp_q] <= req.in_byte;
		rdata_s1 <= hist[rd_addr];
		if (vld_s1) lanes_q[lane_s1] <= mval;
	end

	logic [WIN_AW:0] bw_sum;
	assign bw_sum = bw_q + (WIN_AW+1)'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN; lit_left_q <= '0; match_left_q <= '0; off_q <= '0;
			tok_low_q <= '0; finished_q <= 1'b0; ended_q <= 1'b0;
			wp_q <= '0; bw_q <= '0;
			busy_q <= 1'b0; iss_q <= '0; n_q <= '0; vld_s1 <= 1'b0; lane_s1 <= '0;
			ov_q <= 1'b0; od_q <= '0;
		end else begin
			// load a new response beat, else drop the one taken
			if ((acc && !pull_go) || last_lane) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
			vld_s1 <= issue;
			lane_s1 <= iss_lane[LANE_W-1:0];
			if (issue) iss_q <= iss_lane + CNT_W'(1);
			if (acc && pull_go) begin
				busy_q <= 1'b1;
				n_q <= n_new;
			end else if (acc) begin
				phase_q <= ph_n; lit_left_q <= lit_n; match_left_q <= ml_n;
				off_q <= off_n; tok_low_q <= tl_n; finished_q <= fin_n; ended_q <= end_n;
				if (clr) begin
					wp_q <= '0; bw_q <= '0;
				end else if (lit_wr) begin
					wp_q <= wp_q + WIN_AW'(1);
					if (bw_q[WIN_AW] == 1'b0) bw_q <= bw_q + (WIN_AW+1)'(1);
				end
				od_q.out_data <= lit_wr ? {{(8*PULL_LANES-8){1'b0}}, req.in_byte} : '0;
				od_q.out_count <= lit_wr ? 4'd1 : 4'd0;
				od_q.more_pending <= !fin_n && ph_n == PH_MATCH && ml_n != '0;
				od_q.block_done <= fin_n;
				od_q.status <= st_n;
			end
			// retire the pull once its last lane resolves
			if (last_lane) begin
				busy_q <= 1'b0;
				wp_q <= wp_q + WIN_AW'(n_q);
				bw_q <= (bw_sum > (WIN_AW+1)'(2**WIN_AW)) ? (WIN_AW+1)'(2**WIN_AW) : bw_sum;
				match_left_q <= ml_after;
				if (ml_after == '0) begin
					phase_q <= PH_TOKEN;
					if (ended_q) finished_q <= 1'b1;
				end
				od_q.out_data <= pdata;
				od_q.out_count <= 4'(n_q);
				od_q.more_pending <= ml_after != '0;
				od_q.block_done <= (ml_after == '0) && ended_q;
				od_q.status <= ST_OK;
			end
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.out_data     = od_q.out_data;
	assign rsp.out_count    = od_q.out_count;
	assign rsp.more_pending = od_q.more_pending;
	assign rsp.block_done   = od_q.block_done;
	assign rsp.status       = od_q.status;
endmodule
`default_nettype wire

// ===== rtl/core/lz4d_checker.sv =====
// Port-level checks for the LZ4 block decompressor, bound to the top level.
// Depends on lz4d_pkg.
`default_nettype none
module lz4d_checker import lz4d_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [3:0] out_count,
	input wire logic       more_pending,
	input wire logic       block_done,
	input wire logic [1:0] status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> out_count <= 4'(PULL_LANES))
		else $error("too many bytes in a beat");
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> out_count == 4'd0)
		else $error("bytes on a failed beat");
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && more_pending |-> !block_done)
		else $error("pending match on an ended block");
endmodule

bind lz4_block_decompressor_unit lz4d_checker u_lz4d_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.out_count(rsp.out_count), .more_pending(rsp.more_pending),
	.block_done(rsp.block_done), .status(rsp.status)
);
`default_nettype wire
